// ===== design/ovr_pkg.sv =====
package ovr_pkg;

	localparam int unsigned DEF_RING_DEPTH = 32;
	localparam int unsigned MAX_RESULTS    = 32;

	localparam int unsigned ACT_W   = 2;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned OCC_W   = 16;
	localparam int unsigned SEQ_W   = 8;
	localparam int unsigned REQ_W   = 6;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned ENTRY_W = STAMP_W + OCC_W + SEQ_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_PEEK  = 2'd1,
		ACT_DRAIN = 2'd2,
		ACT_NOP   = 2'd3
	} ovr_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_WT
	} ovr_state_t;

	typedef struct packed {
		logic                    entry_valid;
		logic [STAMP_W-1:0]      res_stamp;
		logic signed [OCC_W-1:0] res_occupancy;
		logic [SEQ_W-1:0]        res_seq;
		logic                    last_of_run;
		logic                    overwrote_oldest;
		logic [CNT_W-1:0]        removed_number;
		logic [CNT_W-1:0]        fill_after;
	} ovr_res_t;

endpackage

// ===== design/ovr_item_if.sv =====
interface ovr_item_if;
	logic                                    valid;
	logic                                    ready;
	logic [ovr_pkg::ACT_W-1:0]               action;
	logic [ovr_pkg::STAMP_W-1:0]             stamp_seconds;
	logic signed [ovr_pkg::OCC_W-1:0]        occupancy;
	logic [ovr_pkg::SEQ_W-1:0]               seq_tag;
	logic [ovr_pkg::REQ_W-1:0]               request_number;

	modport source (
		output valid, action, stamp_seconds, occupancy, seq_tag, request_number,
		input  ready
	);
	modport sink (
		input  valid, action, stamp_seconds, occupancy, seq_tag, request_number,
		output ready
	);
endinterface

// ===== design/ovr_result_if.sv =====
interface ovr_result_if;
	logic                             valid;
	logic                             ready;
	logic                             entry_valid;
	logic [ovr_pkg::STAMP_W-1:0]      res_stamp;
	logic signed [ovr_pkg::OCC_W-1:0] res_occupancy;
	logic [ovr_pkg::SEQ_W-1:0]        res_seq;
	logic                             last_of_run;
	logic                             overwrote_oldest;
	logic [ovr_pkg::CNT_W-1:0]        removed_number;
	logic [ovr_pkg::CNT_W-1:0]        fill_after;

	modport source (
		output valid, entry_valid, res_stamp, res_occupancy, res_seq, last_of_run,
		       overwrote_oldest, removed_number, fill_after,
		input  ready
	);
	modport sink (
		input  valid, entry_valid, res_stamp, res_occupancy, res_seq, last_of_run,
		       overwrote_oldest, removed_number, fill_after,
		output ready
	);
endinterface

// ===== design/ovr_ram.sv =====
module ovr_ram #(
	parameter int unsigned WIDTH = ovr_pkg::ENTRY_W,
	parameter int unsigned DEPTH = ovr_pkg::DEF_RING_DEPTH,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/ovr_wrap_add.sv =====
// pos + step modulo DEPTH; pos < DEPTH and step <= DEPTH, so one subtract wraps it
module ovr_wrap_add #(
	parameter int unsigned DEPTH = ovr_pkg::DEF_RING_DEPTH,
	localparam int unsigned POS_W  = $clog2(DEPTH),
	localparam int unsigned FILL_W = $clog2(DEPTH + 1),
	localparam int unsigned SUM_W  = FILL_W + 1
) (
	input  logic [POS_W-1:0]  pos,
	input  logic [FILL_W-1:0] step,
	output logic [POS_W-1:0]  next_pos
);

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;

	always_comb begin
		sum     = SUM_W'(pos) + SUM_W'(step);
		wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
		next_pos = wrapped[POS_W-1:0];
	end

endmodule

// ===== design/overwrite_ring_with_peek_commit.sv =====
// Push, drain and no-op: result loads into the output register at the accept edge.
// Peek: each entry is a registered RAM read (ST_RD), then an output load (ST_WT) that
// waits until the output register is free; a peek of nothing answers at the accept edge.
// Single RAM read port, one shared wrap adder; no item is accepted during a peek walk.
// Reset (arst_n low, async): pointers, fill level, sequencer and output valid clear;
// ring storage is not cleared and holds garbage until written.
module overwrite_ring_with_peek_commit #(
	parameter int unsigned RING_DEPTH = ovr_pkg::DEF_RING_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	ovr_item_if.sink           item,
	ovr_result_if.source       result
);

	localparam int unsigned POS_W  = $clog2(RING_DEPTH);
	localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
	localparam int unsigned CMP_W  = (FILL_W > ovr_pkg::REQ_W) ? FILL_W : ovr_pkg::REQ_W;
	localparam int unsigned CNT_W  = ovr_pkg::CNT_W;

	// sequencer and ring pointers
	ovr_pkg::ovr_state_t state_q, state_d;
	logic [POS_W-1:0]  wp_q, wp_d;
	logic [POS_W-1:0]  rp_q, rp_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [POS_W-1:0]  addr_q, addr_d;     // peek walk address
	logic [CNT_W-1:0]  remain_q, remain_d; // peek entries still to emit

	// output register
	ovr_pkg::ovr_res_t res_q, res_d;
	logic              res_valid_q;
	logic              load;
	logic              out_free;

	// shared wrap adder operands
	logic [POS_W-1:0]  unit_pos;
	logic [FILL_W-1:0] unit_step;
	logic [POS_W-1:0]  unit_next;

	// ring memory ports
	logic                         ram_we;
	logic                         ram_re;
	logic [ovr_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [ovr_pkg::ENTRY_W-1:0]  ram_rdata;

	ovr_pkg::ovr_action_t act;
	logic              full;
	logic [CMP_W-1:0]  req_x;
	logic [CMP_W-1:0]  fill_x;
	logic [CMP_W-1:0]  n_fill;   // request clamped to fill (drain count)
	logic [CMP_W-1:0]  n_peek;   // also clamped to the result limit

	assign act      = ovr_pkg::ovr_action_t'(item.action);
	assign full     = (fill_q == FILL_W'(RING_DEPTH));
	assign out_free = !res_valid_q || result.ready;
	assign req_x    = CMP_W'(item.request_number);
	assign fill_x   = CMP_W'(fill_q);
	assign n_fill   = (req_x < fill_x) ? req_x : fill_x;
	assign n_peek   = (n_fill > CMP_W'(ovr_pkg::MAX_RESULTS)) ?
		CMP_W'(ovr_pkg::MAX_RESULTS) : n_fill;
	assign ram_wdata = {item.stamp_seconds, item.occupancy, item.seq_tag};

	ovr_wrap_add #(
		.DEPTH(RING_DEPTH)
	) u_wrap (
		.pos     (unit_pos),
		.step    (unit_step),
		.next_pos(unit_next)
	);

	ovr_ram #(
		.WIDTH(ovr_pkg::ENTRY_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ovr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, pointer updates and result build.
	always_comb begin
		state_d   = state_q;
		item.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load      = 1'b0;
		fill_d    = fill_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		addr_d    = addr_q;
		remain_d  = remain_q;
		unit_pos  = rp_q;
		unit_step = '0;
		res_d     = '0;
		res_d.last_of_run = 1'b1;
		res_d.fill_after  = CNT_W'(fill_q);

		case (state_q)
			ovr_pkg::ST_IDLE: begin
				item.ready = out_free;
				case (act)
					ovr_pkg::ACT_PUSH: begin
						unit_pos  = wp_q;
						unit_step = FILL_W'(1);
					end
					ovr_pkg::ACT_DRAIN: begin
						unit_pos  = rp_q;
						unit_step = FILL_W'(n_fill);
					end
					default: begin
						unit_pos  = rp_q;
						unit_step = '0;
					end
				endcase
				if (item.valid && out_free) begin
					case (act)
						ovr_pkg::ACT_PUSH: begin
							ram_we = 1'b1;
							wp_d   = unit_next;
							// full ring: write slot == oldest slot, both move on together
							if (full) begin
								rp_d = unit_next;
								res_d.overwrote_oldest = 1'b1;
							end else begin
								fill_d = fill_q + FILL_W'(1);
							end
							res_d.fill_after = CNT_W'(fill_d);
							load = 1'b1;
						end
						ovr_pkg::ACT_PEEK: begin
							if (n_peek == '0) begin
								load = 1'b1;
							end else begin
								addr_d   = rp_q;
								remain_d = CNT_W'(n_peek);
								state_d  = ovr_pkg::ST_RD;
							end
						end
						ovr_pkg::ACT_DRAIN: begin
							rp_d   = unit_next;
							fill_d = fill_q - FILL_W'(n_fill);
							res_d.removed_number = CNT_W'(n_fill);
							res_d.fill_after     = CNT_W'(fill_d);
							load = 1'b1;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ovr_pkg::ST_RD: begin
				ram_re  = 1'b1;
				state_d = ovr_pkg::ST_WT;
			end
			ovr_pkg::ST_WT: begin
				unit_pos  = addr_q;
				unit_step = FILL_W'(1);
				if (out_free) begin
					load = 1'b1;
					res_d.entry_valid   = 1'b1;
					res_d.res_stamp     = ram_rdata[ovr_pkg::ENTRY_W-1 -: ovr_pkg::STAMP_W];
					res_d.res_occupancy = ram_rdata[ovr_pkg::SEQ_W +: ovr_pkg::OCC_W];
					res_d.res_seq       = ram_rdata[ovr_pkg::SEQ_W-1:0];
					res_d.last_of_run   = (remain_q == CNT_W'(1));
					remain_d = remain_q - CNT_W'(1);
					addr_d   = unit_next;
					state_d  = (remain_q == CNT_W'(1)) ? ovr_pkg::ST_IDLE : ovr_pkg::ST_RD;
				end
			end
			default: begin
				state_d = ovr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			fill_q      <= '0;
			addr_q      <= '0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			fill_q   <= fill_d;
			addr_q   <= addr_d;
			remain_q <= remain_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result word holds until taken
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.entry_valid      = res_q.entry_valid;
	assign result.res_stamp        = res_q.res_stamp;
	assign result.res_occupancy    = res_q.res_occupancy;
	assign result.res_seq          = res_q.res_seq;
	assign result.last_of_run      = res_q.last_of_run;
	assign result.overwrote_oldest = res_q.overwrote_oldest;
	assign result.removed_number   = res_q.removed_number;
	assign result.fill_after       = res_q.fill_after;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("fill level above ring depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && act == ovr_pkg::ACT_PUSH && !full)
		|=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("push into non-full ring did not grow fill");

	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.entry_valid) |-> res_q.last_of_run)
		else $error("non-entry word without last flag");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ovr_pkg::ST_IDLE) |-> (remain_q != '0))
		else $error("peek walk with nothing left");

	a_walk_holds_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ovr_pkg::ST_IDLE) |=> ($stable(fill_q) && $stable(rp_q)))
		else $error("ring pointers moved during peek");

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = ovr_pkg::DEF_RING_DEPTH;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;

	ovr_item_if   item();
	ovr_result_if result();

	overwrite_ring_with_peek_commit #(
		.RING_DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Ring mirror: our own copy of the stored readings and pointers.
	// ------------------------------------------------------------------
	logic [ovr_pkg::STAMP_W-1:0]      mirror_stamp [DEPTH];
	logic signed [ovr_pkg::OCC_W-1:0] mirror_occ   [DEPTH];
	logic [ovr_pkg::SEQ_W-1:0]        mirror_seq   [DEPTH];
	int unsigned                      wr_slot;
	int unsigned                      oldest_slot;
	int unsigned                      held;

	// result words still owed by the block, oldest first
	ovr_pkg::ovr_res_t                results_due[$];

	// run bookkeeping
	int unsigned errors;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned entries_checked;
	int unsigned overwrites_seen;
	int unsigned full_hits;
	int unsigned cycles;

	// stretches with no idling on either side
	bit src_calm;
	bit snk_calm;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	// Apply one accepted input word to the mirror and queue the result
	// words it must produce.
	function automatic void ring_mirror_apply(input ovr_pkg::ovr_action_t act,
			input logic [ovr_pkg::STAMP_W-1:0] stamp,
			input logic signed [ovr_pkg::OCC_W-1:0] occ,
			input logic [ovr_pkg::SEQ_W-1:0] seq, input logic [ovr_pkg::REQ_W-1:0] req);
		ovr_pkg::ovr_res_t w;
		int unsigned       n;
		int unsigned       slot;
		w = '0;
		w.last_of_run = 1'b1;
		n = (int'(req) < held) ? int'(req) : held;
		case (act)
			ovr_pkg::ACT_PUSH: begin
				// full ring: oldest reading is dropped first
				if (held == DEPTH) begin
					oldest_slot = (oldest_slot + 1) % DEPTH;
					held--;
					w.overwrote_oldest = 1'b1;
					overwrites_seen++;
				end
				mirror_stamp[wr_slot] = stamp;
				mirror_occ[wr_slot]   = occ;
				mirror_seq[wr_slot]   = seq;
				wr_slot = (wr_slot + 1) % DEPTH;
				held++;
				if (held == DEPTH)
					full_hits++;
				w.fill_after = ovr_pkg::CNT_W'(held);
				results_due.push_back(w);
			end
			ovr_pkg::ACT_PEEK: begin
				if (n > ovr_pkg::MAX_RESULTS)
					n = ovr_pkg::MAX_RESULTS;
				w.fill_after = ovr_pkg::CNT_W'(held);
				if (n == 0) begin
					// nothing to show: single empty word
					results_due.push_back(w);
				end else begin
					for (int unsigned i = 0; i < n; i++) begin
						slot = (oldest_slot + i) % DEPTH;
						w.entry_valid   = 1'b1;
						w.res_stamp     = mirror_stamp[slot];
						w.res_occupancy = mirror_occ[slot];
						w.res_seq       = mirror_seq[slot];
						w.last_of_run   = (i + 1 == n);
						results_due.push_back(w);
					end
				end
			end
			ovr_pkg::ACT_DRAIN: begin
				// request beyond fill is clamped, ring empties
				oldest_slot = (oldest_slot + n) % DEPTH;
				held -= n;
				w.removed_number = ovr_pkg::CNT_W'(n);
				w.fill_after     = ovr_pkg::CNT_W'(held);
				results_due.push_back(w);
			end
			default: begin
				// no-op: state untouched
				w.fill_after = ovr_pkg::CNT_W'(held);
				results_due.push_back(w);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Source side: one word per call, random gap in front of it.
	// valid stays high across back-to-back words so it is never lowered
	// and raised in the same step.
	// ------------------------------------------------------------------
	task automatic send_word(input ovr_pkg::ovr_action_t act,
			input logic [ovr_pkg::STAMP_W-1:0] stamp,
			input logic signed [ovr_pkg::OCC_W-1:0] occ,
			input logic [ovr_pkg::SEQ_W-1:0] seq, input logic [ovr_pkg::REQ_W-1:0] req);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid          <= 1'b1;
		item.action         <= act;
		item.stamp_seconds  <= stamp;
		item.occupancy      <= occ;
		item.seq_tag        <= seq;
		item.request_number <= req;
		do @(posedge clk); while (item.ready !== 1'b1);
		// accepted at this edge; its results come out no earlier than the next
		ring_mirror_apply(act, stamp, occ, seq, req);
		words_sent++;
	endtask

	// peek, drain and no-op: payload fields are don't-care, fill them with junk
	task automatic send_junk(input ovr_pkg::ovr_action_t act,
			input logic [ovr_pkg::REQ_W-1:0] req);
		send_word(act, $urandom, ovr_pkg::OCC_W'($urandom), ovr_pkg::SEQ_W'($urandom), req);
	endtask

	task automatic push_random();
		send_word(ovr_pkg::ACT_PUSH, $urandom, ovr_pkg::OCC_W'($urandom),
			ovr_pkg::SEQ_W'($urandom), ovr_pkg::REQ_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Sink side: after every accepted result draw a random stall, none while snk_calm.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n !== 1'b1) begin
				result.ready <= 1'b0;
			end else if (result.valid === 1'b1 && result.ready === 1'b1) begin
				stall_left = snk_calm ? 0 : $urandom_range(0, 15);
				result.ready <= (stall_left == 0);
			end else if (stall_left != 0) begin
				stall_left--;
				result.ready <= (stall_left == 0);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted word against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		ovr_pkg::ovr_res_t want;
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (results_due.size() == 0) begin
				flag_mismatch("result word with nothing expected");
			end else begin
				want = results_due.pop_front();
				words_checked++;
				if (want.entry_valid)
					entries_checked++;
				if (result.entry_valid !== want.entry_valid)
					flag_mismatch($sformatf("entry_valid got %b want %b",
						result.entry_valid, want.entry_valid));
				if (result.res_stamp !== want.res_stamp)
					flag_mismatch($sformatf("res_stamp got %h want %h",
						result.res_stamp, want.res_stamp));
				if (result.res_occupancy !== want.res_occupancy)
					flag_mismatch($sformatf("res_occupancy got %0d want %0d",
						result.res_occupancy, want.res_occupancy));
				if (result.res_seq !== want.res_seq)
					flag_mismatch($sformatf("res_seq got %0d want %0d",
						result.res_seq, want.res_seq));
				if (result.last_of_run !== want.last_of_run)
					flag_mismatch($sformatf("last_of_run got %b want %b",
						result.last_of_run, want.last_of_run));
				if (result.overwrote_oldest !== want.overwrote_oldest)
					flag_mismatch($sformatf("overwrote_oldest got %b want %b",
						result.overwrote_oldest, want.overwrote_oldest));
				if (result.removed_number !== want.removed_number)
					flag_mismatch($sformatf("removed_number got %0d want %0d",
						result.removed_number, want.removed_number));
				if (result.fill_after !== want.fill_after)
					flag_mismatch($sformatf("fill_after got %0d want %0d",
						result.fill_after, want.fill_after));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles,
				results_due.size());
			$display("overwrite_ring_with_peek_commit verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty ring: peeks give one empty word, drains remove nothing.
	task automatic test_empty_ring();
		src_calm = 1'b0;
		snk_calm = 1'b0;
		send_junk(ovr_pkg::ACT_PEEK, 6'd4);
		send_junk(ovr_pkg::ACT_PEEK, 6'd0);
		send_junk(ovr_pkg::ACT_DRAIN, 6'd5);
		send_junk(ovr_pkg::ACT_NOP, 6'd63);
	endtask

	// Field extremes on push, then peek/drain edge requests on a short ring.
	task automatic test_field_extremes();
		src_calm = 1'b1;
		snk_calm = 1'b0;
		send_word(ovr_pkg::ACT_PUSH, 32'h0000_0000, -16'sd32768, 8'd0,   6'd0);
		send_word(ovr_pkg::ACT_PUSH, 32'hFFFF_FFFF, 16'sd32767,  8'd255, 6'd63);
		send_word(ovr_pkg::ACT_PUSH, 32'hA5A5_5A5A, -16'sd1,     8'h55,  6'd21);
		send_word(ovr_pkg::ACT_PUSH, 32'h5A5A_A5A5, 16'sd0,      8'hAA,  6'd42);
		send_junk(ovr_pkg::ACT_PEEK, 6'd0);      // zero request: empty word
		send_junk(ovr_pkg::ACT_PEEK, 6'd1);
		send_junk(ovr_pkg::ACT_PEEK, 6'd63);     // clamped to fill
		send_junk(ovr_pkg::ACT_PEEK, 6'd3);
		send_junk(ovr_pkg::ACT_DRAIN, 6'd0);     // drain of zero
		send_junk(ovr_pkg::ACT_DRAIN, 6'd1);
		send_junk(ovr_pkg::ACT_PEEK, 6'd32);
	endtask

	// Drain past the fill level, no-op with every bit set, peek after.
	task automatic test_drain_clamp_and_nop();
		src_calm = 1'b0;
		snk_calm = 1'b1;
		send_junk(ovr_pkg::ACT_DRAIN, 6'd63);    // clamps, ring empties
		send_junk(ovr_pkg::ACT_PEEK, 6'd2);
		send_word(ovr_pkg::ACT_NOP, 32'hFFFF_FFFF, -16'sd1, 8'hFF, 6'h3F);
		send_word(ovr_pkg::ACT_PUSH, 32'h1234_5678, 16'sd100, 8'd7, 6'd0);
		send_word(ovr_pkg::ACT_NOP, 32'h0, 16'sd0, 8'h0, 6'd0);
		send_junk(ovr_pkg::ACT_PEEK, 6'd63);
	endtask

	// Overfill: every push beyond depth drops the oldest; peek the whole
	// ring, including past the maximum run length.
	task automatic test_overwrite_full();
		src_calm = 1'b0;
		snk_calm = 1'b0;
		repeat (DEPTH + 3) push_random();
		snk_calm = 1'b1;
		send_junk(ovr_pkg::ACT_PEEK, 6'd32);
		send_junk(ovr_pkg::ACT_PEEK, 6'd63);
		src_calm = 1'b1;
		push_random();
		push_random();
		snk_calm = 1'b0;
		send_junk(ovr_pkg::ACT_PEEK, 6'd40);
		send_junk(ovr_pkg::ACT_DRAIN, 6'd32);    // empties a full ring
		send_junk(ovr_pkg::ACT_PEEK, 6'd1);
	endtask

	// Random mix, biased toward pushes with occasional bursts so the ring
	// keeps reaching full and wrapping; peek requests mostly near the fill level, drains mostly small.
	task automatic test_random_mix(input int unsigned count);
		int unsigned pick;
		int unsigned i;
		i = 0;
		while (i < count) begin
			if (i % 16 == 0) begin
				src_calm = ($urandom_range(0, 3) == 0);
				snk_calm = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				repeat (8) push_random();
				i += 8;
			end else begin
				if (pick < 48)
					push_random();
				else if (pick < 72)
					send_junk(ovr_pkg::ACT_PEEK, ($urandom_range(0, 3) == 0) ?
						ovr_pkg::REQ_W'($urandom_range(0, 63)) :
						ovr_pkg::REQ_W'($urandom_range(0, held + 2)));
				else if (pick < 92)
					send_junk(ovr_pkg::ACT_DRAIN, ($urandom_range(0, 4) == 0) ?
						ovr_pkg::REQ_W'($urandom_range(0, 63)) :
						ovr_pkg::REQ_W'($urandom_range(0, 4)));
				else
					send_junk(ovr_pkg::ACT_NOP, ovr_pkg::REQ_W'($urandom));
				i++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		errors          = 0;
		words_sent      = 0;
		words_checked   = 0;
		entries_checked = 0;
		overwrites_seen = 0;
		full_hits       = 0;
		cycles          = 0;
		wr_slot         = 0;
		oldest_slot     = 0;
		held            = 0;
		src_calm        = 1'b0;
		snk_calm        = 1'b0;

		arst_n              <= 1'b0;
		item.valid          <= 1'b0;
		item.action         <= ovr_pkg::ACT_NOP;
		item.stamp_seconds  <= '0;
		item.occupancy      <= '0;
		item.seq_tag        <= '0;
		item.request_number <= '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_field_extremes();
		test_drain_clamp_and_nop();
		test_overwrite_full();
		test_random_mix(67);

		item.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		// trailing window: any stray word would show up here
		repeat (20) @(posedge clk);

		$display("sent %0d words, checked %0d result words (%0d peeked entries)",
			words_sent, words_checked, entries_checked);
		$display("ring reached full %0d times, %0d oldest entries overwritten",
			full_hits, overwrites_seen);
		if (errors == 0) begin
			$display("overwrite_ring_with_peek_commit verification clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("overwrite_ring_with_peek_commit verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/ovr_pkg.sv
design/ovr_item_if.sv
design/ovr_result_if.sv
design/ovr_ram.sv
design/ovr_wrap_add.sv
design/overwrite_ring_with_peek_commit.sv
test/tb.sv
